FILE: hdl/bbda_pkg.sv
`default_nettype none

package bbda_pkg;

    // Value width taken from the input and number of decimal digit slots.
    localparam int VALUE_WIDTH = 64;
    localparam int DIGIT_SLOTS = 20;

    // Most characters one conversion may emit, and the width of the count field.
    localparam int MAX_RESULTS = 20;
    localparam int COUNT_W     = 5;

    // Derived widths.
    localparam int BCD_W   = 4 * DIGIT_SLOTS;
    localparam int STEP_W  = $clog2(VALUE_WIDTH);
    localparam int TOTAL_W = $clog2(DIGIT_SLOTS + 1);
    localparam int IDX_W   = $clog2(DIGIT_SLOTS);
    localparam int CMP_W   = (TOTAL_W > COUNT_W) ? TOTAL_W : COUNT_W;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_ZERO = 8'd48;

    typedef struct packed {
        logic [63:0] number;
        logic [7:0]  text_room;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         digit_char;
        logic               has_char;
        logic               last;
        logic [COUNT_W-1:0] written_count;
    } out_item_t;

    // A classified job as it waits in the queue.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [COUNT_W-1:0]     limit;
        logic                   no_room;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NOROOM,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

FILE: hdl/bbda_front.sv
`default_nettype none

module bbda_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire bbda_pkg::in_item_t s_item,
    output logic                  job_valid,
    input  wire logic             job_ready,
    output bbda_pkg::job_t        job
);
    import bbda_pkg::*;

    job_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;
    job_t              incoming;
    logic [7:0]        room_m1;

    // Classify: no room at all, otherwise cap the character budget.
    always_comb begin
        room_m1              = s_item.text_room - 8'd1;
        incoming.value       = s_item.number[VALUE_WIDTH-1:0];
        incoming.no_room     = (s_item.text_room <= 8'd1);
        if (room_m1 > 8'(MAX_RESULTS)) begin
            incoming.limit = COUNT_W'(MAX_RESULTS);
        end else begin
            incoming.limit = room_m1[COUNT_W-1:0];
        end
    end

    assign s_ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = queue_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = job_valid && job_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bbda_back.sv
`default_nettype none

module bbda_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire bbda_pkg::job_t    job,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bbda_pkg::out_item_t    m_item
);
    import bbda_pkg::*;

    // One double-dabble step: add 3 to every digit of 5 or more, then shift in a bit.
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic bit_in);
        logic [BCD_W-1:0] adj;
        logic [3:0]       d;
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
            d = bcd[4*i +: 4];
            adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    back_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [TOTAL_W-1:0]     cnt_reg, cnt_next;
    logic [COUNT_W-1:0]     limit_reg, limit_next;
    logic [COUNT_W-1:0]     emit_reg, emit_next;
    logic [COUNT_W-1:0]     k_reg, k_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_item_reg, m_item_next;
    logic                   out_free;
    logic                   out_load;
    logic [BCD_W-1:0]       bcd_step;
    logic [TOTAL_W-1:0]     total;
    logic [3:0]             cur_digit;
    logic                   is_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign bcd_step  = dabble_step(bcd_reg, bin_reg[VALUE_WIDTH-1]);
    assign total     = (cnt_reg == '0) ? TOTAL_W'(1) : cnt_reg;
    assign cur_digit = bcd_reg[idx_reg*4 +: 4];
    assign is_last   = (k_reg + 1'b1 == emit_reg);

    always_comb begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        limit_next   = limit_reg;
        emit_next    = emit_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        m_item_next  = m_item_reg;
        out_load     = 1'b0;
        job_ready    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    if (job.no_room) begin
                        state_next = ST_NOROOM;
                    end else begin
                        bin_next   = job.value;
                        bcd_next   = '0;
                        cnt_next   = '0;
                        step_next  = STEP_W'(VALUE_WIDTH - 1);
                        limit_next = job.limit;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_NOROOM: begin
                if (out_free) begin
                    out_load                  = 1'b1;
                    m_item_next.digit_char    = '0;
                    m_item_next.has_char      = 1'b0;
                    m_item_next.last          = 1'b1;
                    m_item_next.written_count = '0;
                    state_next                = ST_IDLE;
                end
            end
            ST_CONV: begin
                bcd_next = bcd_step;
                bin_next = bin_reg << 1;
                // The value at most doubles per step, so the digit count grows by one at most.
                if (cnt_reg < TOTAL_W'(DIGIT_SLOTS)) begin
                    if (bcd_step[cnt_reg[IDX_W-1:0]*4 +: 4] != 4'd0) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (step_reg == '0) begin
                    state_next = ST_PREP;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_PREP: begin
                if (CMP_W'(total) > CMP_W'(limit_reg)) begin
                    emit_next = limit_reg;
                end else begin
                    emit_next = COUNT_W'(total);
                end
                idx_next   = IDX_W'(total - 1'b1);
                k_next     = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load                  = 1'b1;
                    m_item_next.digit_char    = CHAR_ZERO + {4'd0, cur_digit};
                    m_item_next.has_char      = 1'b1;
                    m_item_next.last          = is_last;
                    m_item_next.written_count = k_reg + 1'b1;
                    k_next                    = k_reg + 1'b1;
                    idx_next                  = idx_reg - 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        step_reg   <= step_next;
        cnt_reg    <= cnt_next;
        limit_reg  <= limit_next;
        emit_reg   <= emit_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

FILE: hdl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter.
// The input channel (s_valid, s_ready, s_item) takes one transaction per value: a 64-bit
// unsigned number and a buffer size. The result channel (m_valid, m_ready, m_item) gives
// one transaction per character, most significant digit first, with the last one flagged
// and carrying the total character count. A buffer size of 0 or 1 yields a single
// transaction with no character and a count of 0.
// The front accepts and classifies transactions into a two-entry queue, so up to two
// values can be taken while the back is still busy. The back runs a double-dabble
// conversion, one bit per cycle, then emits one character per cycle while the receiver
// keeps up. For each value the back takes the job, runs the 64-step conversion loop,
// prepares the character count and then emits N characters, N at most 20. A value
// with no room skips the conversion and emits only its empty transaction.
// When the receiver stalls, the current character holds in the output register and the
// back waits; the queue keeps accepting until it is full.
// Reset (aresetn low at a clock edge) empties the queue and drops any result in flight.
`default_nettype none

module binary_to_decimal_ascii (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bbda_pkg::in_item_t   s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bbda_pkg::out_item_t       m_item
);
    import bbda_pkg::*;

    // Queue head handed from the front to the back.
    logic job_valid;
    logic job_ready;
    job_t job;

    bbda_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    bbda_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // A transaction that carries a character is an ASCII digit with a nonzero count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.has_char) |->
            (m_item.digit_char >= CHAR_ZERO && m_item.digit_char <= CHAR_ZERO + 8'd9 &&
             m_item.written_count != '0))
    else $error("character transaction out of range");

    // A transaction without a character is the only one of its conversion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.has_char) |-> (m_item.last && m_item.written_count == '0))
    else $error("empty transaction must be last with a zero count");

    // Once a non-final character is taken, the next one of the same value follows at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_item.last) |=>
            (m_valid && m_item.has_char &&
             m_item.written_count == $past(m_item.written_count) + 1'b1))
    else $error("character sequence broken");

endmodule

`default_nettype wire

FILE: verif/binary_to_decimal_ascii_checker.sv
module binary_to_decimal_ascii_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  bbda_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  bbda_pkg::out_item_t m_item,
    output int                  mismatches,
    output int                  waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import bbda_pkg::*;

    // Characters still owed by the block, oldest first.
    out_item_t owed_chars[$];
    out_item_t want;
    int        fail_count = 0;

    assign mismatches = fail_count;

    // Works out the character transactions that one accepted value produces.
    task automatic queue_decimal_text(input in_item_t it);
        logic [VALUE_WIDTH-1:0] rest;
        logic [3:0]             digits [DIGIT_SLOTS];
        int unsigned            count;
        int unsigned            room;
        int unsigned            emit;
        out_item_t              r;
        rest  = it.number[VALUE_WIDTH-1:0];
        room  = 32'(it.text_room);
        count = 0;
        if (room <= 1) begin
            r.digit_char    = 8'd0;
            r.has_char      = 1'b0;
            r.last          = 1'b1;
            r.written_count = '0;
            owed_chars.push_back(r);
            return;
        end
        if (rest == 0) begin
            digits[0] = 4'd0;
            count     = 1;
        end else begin
            while (rest != 0 && count < DIGIT_SLOTS) begin
                digits[count] = 4'(rest % 10);
                rest          = rest / 10;
                count++;
            end
        end
        emit = count;
        if (emit > room - 1) emit = room - 1;
        if (emit > MAX_RESULTS) emit = MAX_RESULTS;
        for (int k = 0; k < emit; k++) begin
            r.digit_char    = CHAR_ZERO + {4'd0, digits[count - 1 - k]};
            r.has_char      = 1'b1;
            r.last          = (k + 1 == emit);
            r.written_count = COUNT_W'(k + 1);
            owed_chars.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (owed_chars.size() == 0) begin
                    $error("unexpected result transaction: char %0d count %0d",
                           m_item.digit_char, m_item.written_count);
                    fail_count++;
                end else begin
                    want = owed_chars.pop_front();
                    if (m_item.digit_char !== want.digit_char) begin
                        $error("digit_char: expected %0d, actual %0d",
                               want.digit_char, m_item.digit_char);
                        fail_count++;
                    end
                    if (m_item.has_char !== want.has_char) begin
                        $error("has_char: expected %0d, actual %0d",
                               want.has_char, m_item.has_char);
                        fail_count++;
                    end
                    if (m_item.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_item.last);
                        fail_count++;
                    end
                    if (m_item.written_count !== want.written_count) begin
                        $error("written_count: expected %0d, actual %0d",
                               want.written_count, m_item.written_count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) queue_decimal_text(s_item);
        end
        waiting <= owed_chars.size();
    end

endmodule

FILE: verif/binary_to_decimal_ascii_tb.sv
// Stimulus and verdict for the binary to decimal ASCII converter. The checker beside the
// block predicts every character transaction and counts mismatches; this module only
// feeds values, stalls the result side, and reports the outcome.
module binary_to_decimal_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbda_pkg::*;

    localparam int RANDOM_VALUES = 445;
    // Random transactions in this window run with no idling on either side, so the
    // block is exercised back to back with its input queue full.
    localparam int STEADY_FIRST  = 150;
    localparam int STEADY_LAST   = 270;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;
    logic      steady  = 1'b0;
    int        mismatches;
    int        waiting;

    always #2 aclk = ~aclk;

    binary_to_decimal_ascii i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    binary_to_decimal_ascii_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    // The receiver stalls in about a third of the cycles, except in the steady window.
    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    // Presents one value and holds it until the block takes the transaction. Idle
    // cycles come first, so valid drops only between transactions and is never
    // lowered and raised again within the same clock edge.
    task automatic send_value(input logic [63:0] number, input logic [7:0] text_room);
        while (!steady && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_item.number    <= number;
        s_item.text_room <= text_room;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        logic [63:0] value;
        logic [63:0] power;
        logic [7:0]  room;
        int          pick;
        int          bits;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero value, including the cases where there is no room at all, and a nonzero value with no room.
        send_value(64'd0, 8'd0);
        send_value(64'd0, 8'd1);
        send_value(64'd0, 8'd2);
        send_value(64'd0, 8'd255);
        send_value(64'd5, 8'd1);
        // Single digits, the boundary from one to two digits, and a three-digit value.
        send_value(64'd7, 8'd2);
        send_value(64'd9, 8'd255);
        send_value(64'd10, 8'd2);
        send_value(64'd10, 8'd3);
        send_value(64'd123, 8'd4);
        send_value(64'd1, 8'd255);
        // Largest value: twenty digits, full room, exact room, short buffers.
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 8'd21);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 8'd20);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 8'd2);
        // Around the twenty-digit threshold.
        send_value(64'd10000000000000000000, 8'd255);
        send_value(64'd9999999999999999999, 8'd255);
        send_value(64'd9999999999999999999, 8'd20);
        // Alternating bit patterns and the top bit alone.
        send_value(64'hAAAA_AAAA_AAAA_AAAA, 8'd128);
        send_value(64'h5555_5555_5555_5555, 8'd64);
        send_value(64'h8000_0000_0000_0000, 8'd255);
        // Runs of zero digits with and without a buffer cut, then two values that fit.
        send_value(64'd1000000, 8'd7);
        send_value(64'd1000000, 8'd8);
        send_value(64'd4294967296, 8'd255);
        send_value(64'd99, 8'd3);

        for (int n = 0; n < RANDOM_VALUES; n++) begin
            steady <= (n >= STEADY_FIRST && n < STEADY_LAST);
            // The value: full random, random magnitude, near a power of ten, or small.
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                value = {$urandom, $urandom};
            end else if (pick < 70) begin
                bits  = $urandom_range(0, 64);
                value = {$urandom, $urandom};
                value = (bits == 0) ? 64'd0 : value >> (64 - bits);
            end else if (pick < 85) begin
                power = 64'd1;
                repeat ($urandom_range(0, 19)) power = power * 64'd10;
                value = power + 64'($urandom_range(0, 2)) - 64'd1;
            end else begin
                value = 64'($urandom_range(0, 999));
            end
            // The buffer size: any, small enough to cut digits, or room for one character at most.
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                room = 8'($urandom_range(0, 255));
            end else if (pick < 90) begin
                room = 8'($urandom_range(0, 22));
            end else begin
                room = 8'($urandom_range(0, 2));
            end
            send_value(value, room);
        end
        s_valid <= 1'b0;
        steady  <= 1'b0;

        // Let the checker count the last value, then let every owed character arrive
        // and watch a little longer for strays.
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop in case the block hangs; the slowest correct run needs far less.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bbda_pkg.sv
hdl/bbda_front.sv
hdl/bbda_back.sv
hdl/binary_to_decimal_ascii.sv
verif/binary_to_decimal_ascii_checker.sv
verif/binary_to_decimal_ascii_tb.sv
